/* rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the property holds in the same cycle.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the property holds in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gfnmf_pkg.sv */
// Package with types, constants and state encodings of the form check block.
package gfnmf_pkg;

    // Field widths.
    localparam int K_W    = 64;
    localparam int BASE_W = 32;
    localparam int C_W    = 32;

    // Trial divisor width and the largest divisor tried: the 100000th prime.
    localparam int DIVR_W = 21;
    localparam logic [DIVR_W-1:0] PRIME_LIMIT = 21'd1299709;

    // Square of a trial divisor.
    localparam int DSQ_W = 2 * DIVR_W;

    // Divider retires two quotient bits per cycle.
    localparam int DIV_STEPS = K_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Exponents of a 64-bit number stay below 64.
    localparam int EXP_W = 6;

    // A 64-bit number has at most 15 distinct prime factors.
    localparam int FAC_DEPTH = 16;
    localparam int FIDX_W    = $clog2(FAC_DEPTH);

    // Roots are kept exact up to 32 bits, larger ones only flagged.
    localparam int ROOT_W = 32;
    localparam int PROD_W = ROOT_W + DIVR_W;

    // Additive constants that can qualify.
    localparam logic signed [C_W-1:0] C_PLUS_ONE  = 32'sd1;
    localparam logic signed [C_W-1:0] C_MINUS_ONE = -32'sd1;

    // Divider status toward the root sequencer.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } gfnmf_div_stat_t;

    // Root sequencer result toward the top level.
    typedef struct packed {
        logic              done;
        logic              big;
        logic [ROOT_W-1:0] value;
    } gfnmf_root_res_t;

    typedef enum logic [3:0] {
        R_IDLE,
        R_TRY,
        R_DIV,
        R_GCD,
        R_COF,
        R_LOAD,
        R_MUL,
        R_ACC,
        R_DONE
    } gfnmf_root_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BASE,
        T_K,
        T_OUT
    } gfnmf_top_state_t;

endpackage

/* rtl/gfn_or_mersenne_form_check_unit.sv */
// Top level: decides whether k*b^n+c is Mersenne-like or generalized-Fermat-like.
// Result: valid in the cycle after the input transfer when base is zero or c is neither
// -1 nor +1; otherwise after one or two root passes, each dividing by the trial divisors
// (2 and the odd numbers up to min(sqrt(n), 1299709)) in turn on the shared divider.
// Throughput: one item at a time; the next item is taken after the result transfer.
// Reset: synchronous, active low aresetn returns both sequencers to idle.
module gfn_or_mersenne_form_check_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gfnmf_pkg::K_W-1:0]           s_k,
    input  logic [gfnmf_pkg::BASE_W-1:0]        s_base,
    input  logic signed [gfnmf_pkg::C_W-1:0]    s_sign_term,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_special_form
);

    gfnmf_pkg::gfnmf_top_state_t       state_reg, state_next;

    logic [gfnmf_pkg::K_W-1:0]         k_reg;
    logic                              minus_reg;
    logic [gfnmf_pkg::ROOT_W-1:0]      broot_reg;
    logic                              res_reg;

    logic                              root_start;
    logic [gfnmf_pkg::K_W-1:0]         root_n;
    gfnmf_pkg::gfnmf_root_res_t        rres;

    logic                              in_xfer;
    logic                              qualifies;
    logic                              in_minus;
    logic                              base_fail;
    logic                              k_big;
    logic                              k_ok;

    gfnmf_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .n_in    (root_n),
        .res     (rres)
    );

    // Decode of the incoming item and of the root results.
    always_comb begin
        in_xfer   = s_valid && s_ready;
        in_minus  = (s_sign_term == gfnmf_pkg::C_MINUS_ONE);
        qualifies = (s_base != '0) && (in_minus || (s_sign_term == gfnmf_pkg::C_PLUS_ONE));
        base_fail = minus_reg && (rres.big || (rres.value != gfnmf_pkg::ROOT_W'(2)));
        k_big     = (k_reg > gfnmf_pkg::K_W'(1));
        k_ok      = !rres.big && (minus_reg ? (rres.value == gfnmf_pkg::ROOT_W'(2))
                                            : (rres.value == broot_reg));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gfnmf_pkg::T_IDLE: begin
                if (in_xfer) state_next = qualifies ? gfnmf_pkg::T_BASE : gfnmf_pkg::T_OUT;
            end
            gfnmf_pkg::T_BASE: begin
                if (rres.done) begin
                    state_next = (!base_fail && k_big) ? gfnmf_pkg::T_K : gfnmf_pkg::T_OUT;
                end
            end
            gfnmf_pkg::T_K: if (rres.done) state_next = gfnmf_pkg::T_OUT;
            gfnmf_pkg::T_OUT: if (m_ready) state_next = gfnmf_pkg::T_IDLE;
            default: state_next = gfnmf_pkg::T_IDLE;
        endcase
    end

    // Outputs: handshakes and root launches.
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        root_start = 1'b0;
        root_n     = k_reg;
        unique case (state_reg)
            gfnmf_pkg::T_IDLE: begin
                s_ready    = 1'b1;
                root_start = s_valid && qualifies;
                root_n     = {{(gfnmf_pkg::K_W - gfnmf_pkg::BASE_W){1'b0}}, s_base};
            end
            gfnmf_pkg::T_BASE: root_start = rres.done && !base_fail && k_big;
            gfnmf_pkg::T_OUT:  m_valid    = 1'b1;
            default:           root_start = 1'b0;
        endcase
        m_is_special_form = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gfnmf_pkg::T_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Item registers and the result bit.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gfnmf_pkg::T_IDLE: begin
                if (in_xfer) begin
                    k_reg     <= s_k;
                    minus_reg <= in_minus;
                    res_reg   <= 1'b0;
                end
            end
            gfnmf_pkg::T_BASE: begin
                if (rres.done) begin
                    broot_reg <= rres.value;
                    res_reg   <= !base_fail && !k_big;
                end
            end
            gfnmf_pkg::T_K: begin
                if (rres.done) res_reg <= k_ok;
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

/* rtl/gfnmf_div.sv */
// Shared restoring divider: 64-bit dividend by a 21-bit divisor, two bits per cycle.
module gfnmf_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [gfnmf_pkg::K_W-1:0]        dividend,
    input  logic [gfnmf_pkg::DIVR_W-1:0]     divisor,
    output gfnmf_pkg::gfnmf_div_stat_t       stat,
    output logic [gfnmf_pkg::K_W-1:0]        quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [gfnmf_pkg::DCNT_W-1:0]      cnt_reg;
    logic [gfnmf_pkg::K_W-1:0]         q_reg;
    logic [gfnmf_pkg::DIVR_W-1:0]      r_reg;
    logic [gfnmf_pkg::DIVR_W-1:0]      d_reg;

    logic [gfnmf_pkg::DIVR_W:0]        t1;
    logic [gfnmf_pkg::DIVR_W:0]        t2;
    logic                              ge1;
    logic                              ge2;
    logic [gfnmf_pkg::DIVR_W-1:0]      r1;
    logic [gfnmf_pkg::DIVR_W-1:0]      r_next;
    logic [gfnmf_pkg::K_W-1:0]         q_next;

    // Two dependent restoring steps; the dividend shifts out as quotient bits shift in.
    always_comb begin
        t1     = {r_reg, q_reg[gfnmf_pkg::K_W-1]};
        ge1    = (t1 >= {1'b0, d_reg});
        r1     = ge1 ? gfnmf_pkg::DIVR_W'(t1 - {1'b0, d_reg})
                     : t1[gfnmf_pkg::DIVR_W-1:0];
        t2     = {r1, q_reg[gfnmf_pkg::K_W-2]};
        ge2    = (t2 >= {1'b0, d_reg});
        r_next = ge2 ? gfnmf_pkg::DIVR_W'(t2 - {1'b0, d_reg})
                     : t2[gfnmf_pkg::DIVR_W-1:0];
        q_next = {q_reg[gfnmf_pkg::K_W-3:0], ge1, ge2};
    end

    // Control: count the steps and pulse done after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= gfnmf_pkg::DCNT_W'(gfnmf_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (r_reg == '0);
    assign quotient      = q_reg;

endmodule

/* rtl/gfnmf_root.sv */
// Perfect-power root sequencer: trial division, exponent gcd and root product.
module gfnmf_root (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gfnmf_pkg::K_W-1:0]     n_in,
    output gfnmf_pkg::gfnmf_root_res_t    res
);

    gfnmf_pkg::gfnmf_root_state_t      state_reg, state_next;

    logic [gfnmf_pkg::K_W-1:0]         n_reg;
    logic [gfnmf_pkg::K_W-1:0]         n_orig_reg;
    logic [gfnmf_pkg::DIVR_W-1:0]      d_reg;
    logic [gfnmf_pkg::DSQ_W-1:0]       dsq_reg;
    logic [gfnmf_pkg::EXP_W-1:0]       e_reg;
    logic [gfnmf_pkg::EXP_W-1:0]       g_reg;
    logic [gfnmf_pkg::EXP_W-1:0]       ga_reg;
    logic [gfnmf_pkg::EXP_W-1:0]       gb_reg;
    logic [gfnmf_pkg::FIDX_W-1:0]      cnt_reg;
    logic [gfnmf_pkg::FIDX_W-1:0]      idx_reg;
    logic [gfnmf_pkg::DIVR_W-1:0]      fac_rd_reg;
    logic [gfnmf_pkg::EXP_W-1:0]       rem_e_reg;
    logic [gfnmf_pkg::ROOT_W-1:0]      root_reg;
    logic                              big_reg;
    logic [gfnmf_pkg::PROD_W-1:0]      prod_reg;

    logic [gfnmf_pkg::DIVR_W-1:0]      fac_mem [gfnmf_pkg::FAC_DEPTH];
    logic [gfnmf_pkg::EXP_W-1:0]       exp_mem [gfnmf_pkg::FAC_DEPTH];

    logic                              div_start;
    logic [gfnmf_pkg::K_W-1:0]         div_dividend;
    gfnmf_pkg::gfnmf_div_stat_t        div_stat;
    logic [gfnmf_pkg::K_W-1:0]         div_quot;

    logic                              stop;
    logic                              last_entry;

    gfnmf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Trial division ends once the divisor passes PRIME_LIMIT or the divisor squared exceeds n.
    assign stop       = (d_reg > gfnmf_pkg::PRIME_LIMIT) ||
                        ({{(gfnmf_pkg::K_W - gfnmf_pkg::DSQ_W){1'b0}}, dsq_reg} > n_reg);
    assign last_entry = (idx_reg == cnt_reg - 1'b1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gfnmf_pkg::R_IDLE: if (start) state_next = gfnmf_pkg::R_TRY;
            gfnmf_pkg::R_TRY: begin
                state_next = stop ? gfnmf_pkg::R_COF : gfnmf_pkg::R_DIV;
            end
            gfnmf_pkg::R_DIV: begin
                if (div_stat.done && !div_stat.rem_zero) begin
                    state_next = (e_reg != '0) ? gfnmf_pkg::R_GCD : gfnmf_pkg::R_TRY;
                end
            end
            gfnmf_pkg::R_GCD: if (gb_reg == '0) state_next = gfnmf_pkg::R_TRY;
            gfnmf_pkg::R_COF: begin
                if ((n_reg > gfnmf_pkg::K_W'(1)) || (cnt_reg == '0)) begin
                    state_next = gfnmf_pkg::R_DONE;
                end else begin
                    state_next = gfnmf_pkg::R_LOAD;
                end
            end
            gfnmf_pkg::R_LOAD: state_next = gfnmf_pkg::R_MUL;
            gfnmf_pkg::R_MUL: begin
                if (rem_e_reg != '0) begin
                    state_next = gfnmf_pkg::R_ACC;
                end else begin
                    state_next = last_entry ? gfnmf_pkg::R_DONE : gfnmf_pkg::R_LOAD;
                end
            end
            gfnmf_pkg::R_ACC: begin
                state_next = (prod_reg[gfnmf_pkg::PROD_W-1:gfnmf_pkg::ROOT_W] != '0)
                           ? gfnmf_pkg::R_DONE : gfnmf_pkg::R_MUL;
            end
            // A new pass may start straight from the done state.
            gfnmf_pkg::R_DONE: state_next = start ? gfnmf_pkg::R_TRY : gfnmf_pkg::R_IDLE;
            default:           state_next = gfnmf_pkg::R_IDLE;
        endcase
    end

    // Outputs: divider launches and the result.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = n_reg;
        unique case (state_reg)
            gfnmf_pkg::R_TRY: div_start = !stop;
            gfnmf_pkg::R_DIV: begin
                div_start    = div_stat.done && div_stat.rem_zero;
                div_dividend = div_quot;
            end
            default: div_start = 1'b0;
        endcase
        res.done  = (state_reg == gfnmf_pkg::R_DONE);
        res.big   = big_reg;
        res.value = root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gfnmf_pkg::R_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath, stepped by the sequencer state.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            gfnmf_pkg::R_IDLE, gfnmf_pkg::R_DONE: begin
                if (start) begin
                    n_reg      <= n_in;
                    n_orig_reg <= n_in;
                    d_reg      <= gfnmf_pkg::DIVR_W'(2);
                    dsq_reg    <= gfnmf_pkg::DSQ_W'(4);
                    e_reg      <= '0;
                    g_reg      <= '0;
                    cnt_reg    <= '0;
                    root_reg   <= gfnmf_pkg::ROOT_W'(1);
                    big_reg    <= 1'b0;
                end
            end
            gfnmf_pkg::R_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        n_reg <= div_quot;
                        e_reg <= e_reg + 1'b1;
                    end else begin
                        // Record a found factor and move to the next odd divisor.
                        if (e_reg != '0) begin
                            fac_mem[cnt_reg] <= d_reg;
                            exp_mem[cnt_reg] <= e_reg;
                            cnt_reg          <= cnt_reg + 1'b1;
                            ga_reg           <= g_reg;
                            gb_reg           <= e_reg;
                        end
                        e_reg <= '0;
                        if (d_reg == gfnmf_pkg::DIVR_W'(2)) begin
                            d_reg   <= gfnmf_pkg::DIVR_W'(3);
                            dsq_reg <= gfnmf_pkg::DSQ_W'(9);
                        end else begin
                            d_reg   <= d_reg + gfnmf_pkg::DIVR_W'(2);
                            dsq_reg <= dsq_reg + gfnmf_pkg::DSQ_W'({d_reg, 2'b00})
                                               + gfnmf_pkg::DSQ_W'(4);
                        end
                    end
                end
            end
            gfnmf_pkg::R_GCD: begin
                // Subtractive gcd of the running gcd and the new exponent.
                if (gb_reg == '0) begin
                    g_reg <= ga_reg;
                end else if (ga_reg >= gb_reg) begin
                    ga_reg <= ga_reg - gb_reg;
                end else begin
                    ga_reg <= gb_reg;
                    gb_reg <= ga_reg;
                end
            end
            gfnmf_pkg::R_COF: begin
                // A leftover cofactor forces gcd one, so the root is the number itself.
                if (n_reg > gfnmf_pkg::K_W'(1)) begin
                    root_reg <= n_orig_reg[gfnmf_pkg::ROOT_W-1:0];
                    big_reg  <= (n_orig_reg[gfnmf_pkg::K_W-1:gfnmf_pkg::ROOT_W] != '0);
                end
                idx_reg <= '0;
            end
            gfnmf_pkg::R_LOAD: begin
                fac_rd_reg <= fac_mem[idx_reg];
                rem_e_reg  <= exp_mem[idx_reg];
            end
            gfnmf_pkg::R_MUL: begin
                // One multiply for each g of the exponent.
                if (rem_e_reg == '0) begin
                    idx_reg <= idx_reg + 1'b1;
                end else begin
                    prod_reg  <= gfnmf_pkg::PROD_W'(root_reg) * gfnmf_pkg::PROD_W'(fac_rd_reg);
                    rem_e_reg <= rem_e_reg - g_reg;
                end
            end
            gfnmf_pkg::R_ACC: begin
                root_reg <= prod_reg[gfnmf_pkg::ROOT_W-1:0];
                big_reg  <= (prod_reg[gfnmf_pkg::PROD_W-1:gfnmf_pkg::ROOT_W] != '0);
            end
            default: begin
                big_reg <= big_reg;
            end
        endcase
    end

endmodule

/* rtl/gfnmf_chk.sv */
// Port checker for the form check block, bound to the top level.
`include "assert_macros.svh"

module gfnmf_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [gfnmf_pkg::K_W-1:0]           s_k,
    input logic [gfnmf_pkg::BASE_W-1:0]        s_base,
    input logic signed [gfnmf_pkg::C_W-1:0]    s_sign_term,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_is_special_form
);

    // Only one item is in flight, so a pending result blocks the input.
    `ASSERT_SAME(a_one_in_flight, aclk, aresetn, m_valid, !s_ready, "input ready with result pending")
    // After an input transfer the block is busy.
    `ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready, "ready right after input")
    // After a result transfer the block is idle again.
    `ASSERT_NEXT(a_idle_after_out, aclk, aresetn, m_valid && m_ready, s_ready && !m_valid, "not idle after result")
    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_is_special_form), "stalled result changed")

endmodule

bind gfn_or_mersenne_form_check_unit gfnmf_chk u_gfnmf_chk (.*);

/* verif/gfn_or_mersenne_form_check_unit_test.sv */
// Testbench of the form check block: directed table, random forms and a checking predictor.
module gfn_or_mersenne_form_check_unit_test;

    localparam int          HALF_PERIOD = 4;
    localparam int          IDLE_LIMIT  = 300000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          RAND_ITEMS  = 20;
    localparam logic [63:0] K_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [gfnmf_pkg::K_W-1:0]            s_k = '0;
    logic [gfnmf_pkg::BASE_W-1:0]         s_base = '0;
    logic signed [gfnmf_pkg::C_W-1:0]     s_sign_term = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic                                 m_is_special_form;

    // One row of the directed stimulus; known marks a result typed in by hand.
    typedef struct {
        logic [gfnmf_pkg::K_W-1:0]        k;
        logic [gfnmf_pkg::BASE_W-1:0]     base;
        logic signed [gfnmf_pkg::C_W-1:0] c;
        bit                               known;
        bit                               flag;
    } form_row_t;

    bit  expected_flags[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;

    gfn_or_mersenne_form_check_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_k               (s_k),
        .s_base            (s_base),
        .s_sign_term       (s_sign_term),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_special_form (m_is_special_form)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Perfect-power root by trial division up to PRIME_LIMIT.
    function automatic logic [63:0] perfect_root(logic [63:0] n);
        logic [63:0] factors[$];
        int          powers[$];
        logic [63:0] d;
        logic [63:0] root;
        int          e;
        int          g;
        int          a;
        int          b;
        int          t;
        d = 2;
        while (d <= gfnmf_pkg::PRIME_LIMIT && d * d <= n) begin
            if (n % d == 0) begin
                e = 0;
                while (n % d == 0) begin
                    n = n / d;
                    e++;
                end
                factors.push_back(d);
                powers.push_back(e);
            end
            d = (d == 2) ? 3 : d + 2;
        end
        // A leftover cofactor counts as one prime of power one.
        if (n > 1) begin
            factors.push_back(n);
            powers.push_back(1);
        end
        if (factors.size() == 0) return 64'd1;
        g = powers[0];
        foreach (powers[i]) begin
            a = g;
            b = powers[i];
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            g = a;
        end
        root = 1;
        foreach (factors[i]) repeat (powers[i] / g) root = root * factors[i];
        return root;
    endfunction

    // Decides whether k*b^n+c is Mersenne-like or generalized-Fermat-like.
    function automatic bit form_qualifies(logic [63:0] k, logic [31:0] base,
                                          logic signed [31:0] c);
        logic [63:0] base_root;
        logic [63:0] k_root;
        if (base == 0) return 1'b0;
        if (c != gfnmf_pkg::C_MINUS_ONE && c != gfnmf_pkg::C_PLUS_ONE) return 1'b0;
        base_root = perfect_root({32'd0, base});
        if (c == gfnmf_pkg::C_MINUS_ONE && base_root != 2) return 1'b0;
        if (k > 1) begin
            k_root = perfect_root(k);
            if (c == gfnmf_pkg::C_MINUS_ONE && k_root != 2) return 1'b0;
            if (c == gfnmf_pkg::C_PLUS_ONE && k_root != base_root) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Offers one form and waits for its transfer; the sender may idle first.
    task automatic send_form(input logic [63:0] k, input logic [31:0] base,
                             input logic signed [31:0] c, input bit known, input bit flag);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid     <= 1'b1;
        s_k         <= k;
        s_base      <= base;
        s_sign_term <= c;
        do @(posedge aclk); while (!s_ready);
        expected_flags.push_back(known ? flag : form_qualifies(k, base, c));
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_flags.size() == 0) begin
                report_mismatch("result with no expectation waiting");
            end else begin
                if (m_is_special_form !== expected_flags[0])
                    report_mismatch($sformatf("is_special_form %b, expected %b",
                                              m_is_special_form, expected_flags[0]));
                void'(expected_flags.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("gfn_or_mersenne_form_check_unit test failed");
                $finish;
            end
        end
    end

    // Power r^e, stopping before it leaves the given width.
    function automatic logic [63:0] bounded_power(int r, int e, int bits);
        logic [63:0] v;
        logic [63:0] top;
        top = (bits == 64) ? K_MAX : ((64'd1 << bits) - 1);
        v = 1;
        repeat (e) if (v <= top / r) v = v * r;
        return v;
    endfunction

    // Random number of the given width whose factoring stays short.
    function automatic logic [63:0] random_number(int bits);
        logic [63:0] m;
        case ($urandom_range(4))
            0: return $urandom_range(65535);
            1: return bounded_power($urandom_range(2, 12), $urandom_range(1, 40), bits);
            2: begin
                m = $urandom_range(1, 4095);
                m = m << $urandom_range(bits - 1);
                return (bits == 64) ? m : (m & ((64'd1 << bits) - 1));
            end
            3: return $urandom_range(1);
            default: return bounded_power(2, $urandom_range(1, bits - 1), bits);
        endcase
    endfunction

    task automatic send_random_form();
        logic [63:0]        k;
        logic [31:0]        base;
        logic signed [31:0] c;
        int                 r;
        int                 pick;
        pick = $urandom_range(99);
        c = (pick < 40) ? gfnmf_pkg::C_MINUS_ONE
          : (pick < 80) ? gfnmf_pkg::C_PLUS_ONE : $urandom;
        k    = random_number(64);
        base = random_number(32);
        // Many forms share a root, so that equal roots are met often.
        if ($urandom_range(2) == 0) begin
            r = (c == gfnmf_pkg::C_MINUS_ONE) ? 2 : $urandom_range(2, 15);
            k    = bounded_power(r, $urandom_range(1, 20), 64);
            base = bounded_power(r, $urandom_range(1, 10), 32);
        end
        send_form(k, base, c, 1'b0, 1'b0);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_flags.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Directed rows: extremes, each special case and each kind of constant.
    form_row_t directed_rows[] = '{
        '{64'd0,         32'd0,          gfnmf_pkg::C_MINUS_ONE, 1'b1, 1'b0},
        '{K_MAX,         32'd0,          gfnmf_pkg::C_PLUS_ONE,  1'b1, 1'b0},
        '{K_MAX,         32'hFFFF_FFFF,  32'sh7FFF_FFFF,         1'b1, 1'b0},
        '{64'd5,         32'd7,          32'sh8000_0000,         1'b1, 1'b0},
        '{64'd9,         32'd9,          32'sd0,                 1'b1, 1'b0},
        '{64'd1,         32'd2,          gfnmf_pkg::C_MINUS_ONE, 1'b1, 1'b1},
        '{64'd0,         32'd4,          gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd1,         32'd1,          gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd1,         32'd1,          gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'h8000_0000_0000_0000, 32'h8000_0000, gfnmf_pkg::C_PLUS_ONE, 1'b0, 1'b0},
        '{64'h8000_0000_0000_0000, 32'd8, gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd9,         32'd27,         gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd12,        32'd12,         gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd36,        32'd6,          gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd36,        32'd6,          gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd20014,     32'd20014,      gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd3,         32'd2,          gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd0,         32'hFFFF_FFFF,  gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd1,         32'hFFFF_FFFF,  gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd2,         32'h4000_0000,  gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0},
        '{64'd1024,      32'd32,         gfnmf_pkg::C_PLUS_ONE,  1'b0, 1'b0},
        '{64'd27,        32'd9,          gfnmf_pkg::C_MINUS_ONE, 1'b0, 1'b0}
    };

    // Stimulus: reset, directed table, then random forms in four idling phases.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_form(directed_rows[i].k, directed_rows[i].base, directed_rows[i].c,
                      directed_rows[i].known, directed_rows[i].flag);
        wait_drained();
        for (int phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 12 : 0;
            rx_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 12 : 0;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // A long hold-off on the result side while forms keep coming.
                if (phase == 0 && n == 5) begin
                    hold_request <= 1'b1;
                    @(posedge aclk);
                    hold_request <= 1'b0;
                end
                send_random_form();
            end
            wait_drained();
        end
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_flags.size() == 0) begin
            $display("gfn_or_mersenne_form_check_unit test passed");
        end else begin
            $display("gfn_or_mersenne_form_check_unit test failed");
        end
        $finish;
    end

endmodule
